// ===== hw/rtl/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// ctp_pkg: shared types and constants for the CIDR text parser
// Holds the hand-off record between the scanner and the finishing stage.
// ----------------------------------------------------------------------------
package ctp_pkg;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_TRIMMED = 2'd1;
	localparam logic [1:0] STATUS_ERROR   = 2'd2;

	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_ADDR   = 2'd1;
	localparam logic [1:0] PH_PREFIX = 2'd2;
	localparam logic [1:0] PH_BADPFX = 2'd3;

	// Snapshot of the scanner state at the last character of a string.
	typedef struct packed {
		logic [1:0]       phase;
		logic [8:0]       quad_octet;
		logic [2:0]       quad_dots;
		logic [31:0]      quad_value;
		logic             quad_bad;
		logic [7:0][15:0] groups;
		logic [3:0]       groups_left;
		logic [2:0]       hex_digits;
		logic [15:0]      hex_word;
		logic [3:0]       gap_index;
		logic             gap_seen;
		logic             six_bad;
		logic             six_done;
		logic [8:0]       tail_octet;
		logic [2:0]       tail_dots;
		logic [31:0]      tail_value;
		logic             tail_bad;
		logic [7:0]       prefix_value;
		logic             prefix_digits;
	} scan_rec_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_ipv6;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_len;
	} result_t;

endpackage

// ===== hw/rtl/ctp_scanner.sv =====
// ----------------------------------------------------------------------------
// ctp_scanner: character scanner
// Updates the dotted-quad, hex-group and prefix accumulators one character per
// cycle and hands a snapshot of them on at the last character of a string.
// ----------------------------------------------------------------------------
module ctp_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         char_code,
	input  logic               is_last,
	output logic               rec_valid,
	output ctp_pkg::scan_rec_t rec
);
	import ctp_pkg::*;

	scan_rec_t st_q, nx, rst_v;
	logic      colon_q, colon_n;

	always_comb begin
		rst_v = '0;
		rst_v.phase = PH_FIRST;
		rst_v.groups_left = 4'd8;
	end

	function automatic logic [45:0] dstep(input logic [7:0] c, input logic [8:0] oct,
			input logic [2:0] dots, input logic [31:0] val, input logic bad);
		logic [12:0] v;
		logic [8:0]  o;
		logic [2:0]  d;
		logic [31:0] w;
		logic        b;
		o = oct; d = dots; w = val; b = bad;
		v = 13'(oct) * 13'd10 + 13'(c - 8'h30);
		if (!bad) begin
			if (c >= 8'h30 && c <= 8'h39) begin
				if (v > 13'd255) b = 1'b1;
				else o = v[8:0];
			end else if (c == 8'h2e) begin
				if (dots >= 3'd3) b = 1'b1;
				else begin
					w = (val << 8) + 32'(oct);
					o = '0;
					d = dots + 3'd1;
				end
			end else begin
				b = 1'b1;
			end
		end
		return {o, d, w, b, 1'b0};
	endfunction

	always_comb begin
		logic [45:0] q, t;
		logic [7:0]  lc;
		logic [3:0]  hd;
		logic [11:0] pv;
		nx = st_q;
		colon_n = colon_q;
		lc = char_code | 8'h20;
		hd = 4'(st_q.hex_digits) + 4'd1;
		pv = 12'(st_q.prefix_value) * 12'd10 + 12'(char_code - 8'h30);
		q = dstep(char_code, st_q.quad_octet, st_q.quad_dots, st_q.quad_value,
			st_q.quad_bad);
		t = dstep(char_code, st_q.tail_octet, st_q.tail_dots, st_q.tail_value,
			st_q.tail_bad);
		if (st_q.phase == PH_FIRST || st_q.phase == PH_ADDR) begin
			if (char_code == 8'h2f) begin
				nx.phase = PH_PREFIX;
			end else begin
				nx.phase = PH_ADDR;
				{nx.quad_octet, nx.quad_dots, nx.quad_value, nx.quad_bad} = q[45:1];
				{nx.tail_octet, nx.tail_dots, nx.tail_value, nx.tail_bad} = t[45:1];
				if (st_q.six_bad || st_q.six_done ||
						(st_q.phase == PH_FIRST && char_code == 8'h3a)) begin
					// IPv6 parse is finished or skips a leading colon.
				end else if (char_code == 8'h3a) begin
					if (st_q.hex_digits != 3'd0) begin
						nx.groups[3'(4'd8 - st_q.groups_left)] = st_q.hex_word;
						nx.groups_left = st_q.groups_left - 4'd1;
						if (st_q.groups_left == 4'd1) begin
							nx.six_bad = 1'b1;
						end else begin
							nx.hex_digits = '0;
							nx.hex_word = '0;
							{nx.tail_octet, nx.tail_dots, nx.tail_value, nx.tail_bad} = '0;
							colon_n = 1'b1;
						end
					end else if (!st_q.gap_seen) begin
						nx.gap_seen = 1'b1;
						nx.gap_index = 4'd8 - st_q.groups_left;
						{nx.tail_octet, nx.tail_dots, nx.tail_value, nx.tail_bad} = '0;
						colon_n = 1'b1;
					end else begin
						nx.six_bad = 1'b1;
					end
				end else if (char_code == 8'h2e && st_q.hex_digits != 3'd0) begin
					if (st_q.groups_left < 4'd2 || !colon_q) nx.six_bad = 1'b1;
					else nx.six_done = 1'b1;
				end else begin
					nx.hex_digits = hd[2:0];
					if (hd > 4'd4) nx.six_bad = 1'b1;
					else if (char_code >= 8'h30 && char_code <= 8'h39)
						nx.hex_word = {st_q.hex_word[11:0], char_code[3:0]};
					else if (lc >= 8'h61 && lc <= 8'h66)
						nx.hex_word = {st_q.hex_word[11:0], 4'(lc - 8'h57)};
					else nx.six_bad = 1'b1;
				end
			end
		end else if (st_q.phase == PH_PREFIX) begin
			if (char_code >= 8'h30 && char_code <= 8'h39) begin
				nx.prefix_value = (pv > 12'd255) ? 8'd255 : pv[7:0];
				nx.prefix_digits = 1'b1;
			end else begin
				nx.phase = PH_BADPFX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rst_v;
			colon_q <= 1'b0;
			rec_valid <= 1'b0;
			rec <= '0;
		end else begin
			rec_valid <= in_valid && is_last;
			if (in_valid) begin
				rec <= nx;
				if (is_last) begin
					st_q <= rst_v;
					colon_q <= 1'b0;
				end else begin
					st_q <= nx;
					colon_q <= colon_n;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ctp_finish.sv =====
// ----------------------------------------------------------------------------
// ctp_finish: result builder
// Expands the IPv6 gap, picks the family, checks the prefix and clears host
// bits, over two registered stages.
// ----------------------------------------------------------------------------
module ctp_finish #(
	parameter int ENABLE_IPV6 = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  ctp_pkg::scan_rec_t rec,
	output logic               res_valid,
	output ctp_pkg::result_t   res
);
	import ctp_pkg::*;

	// Stage 1: family and address.
	logic        v6_s1, err_s1, slash_s1, badpfx_s1, pdig_s1, val_s1;
	logic [7:0]  pval_s1;
	logic [63:0] hi_s1, lo_s1;

	logic [7:0][15:0] g, o;
	logic             six_ok, quad_ok;
	logic [3:0]       n, w;
	logic [15:0]      word;
	logic [2:0]       nib;
	logic [31:0]      tq, tt;

	always_comb begin
		g = rec.groups;
		n = rec.groups_left;
		word = rec.hex_word;
		nib = rec.hex_digits;
		six_ok = (ENABLE_IPV6 != 0) && !rec.six_bad;
		tq = (rec.quad_value << 8) | 32'(rec.quad_octet);
		tt = (rec.tail_value << 8) | 32'(rec.tail_octet);
		quad_ok = !rec.quad_bad && rec.quad_dots == 3'd3;
		if (rec.six_done) begin
			if (rec.tail_bad || rec.tail_dots != 3'd3) six_ok = 1'b0;
			g[3'(4'd8 - n)] = tt[31:16];
			n = n - 4'd1;
			word = tt[15:0];
			nib = 3'd1;
		end
		if (nib == 3'd0 && !rec.gap_seen) six_ok = 1'b0;
		g[3'(4'd8 - n)] = word;
		n = n - 4'd1;
		w = 4'd8 - n;
		o = g;
		if (n != 4'd0) begin
			if (!rec.gap_seen) six_ok = 1'b0;
			// Groups at and above the gap move up by n; the gap fills with zeros.
			for (int k = 0; k < 8; k++) begin
				if (4'(k) >= rec.gap_index && 4'(k) < rec.gap_index + n)
					o[k] = '0;
				else if (4'(k) >= rec.gap_index + n && 4'(k) < w + n)
					o[k] = g[3'(4'(k) - n)];
				else
					o[k] = g[k];
			end
		end else if (rec.gap_seen) begin
			six_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else begin
			val_s1 <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		slash_s1 <= rec.phase[1];
		badpfx_s1 <= rec.phase == PH_BADPFX;
		pdig_s1 <= rec.prefix_digits;
		pval_s1 <= rec.prefix_value;
		v6_s1 <= !quad_ok && six_ok;
		err_s1 <= !quad_ok && !six_ok;
		hi_s1 <= quad_ok ? 64'd0 : {o[0], o[1], o[2], o[3]};
		lo_s1 <= quad_ok ? {32'd0, tq} : {o[4], o[5], o[6], o[7]};
	end

	// Stage 2: prefix check and masking.
	logic [63:0] mhi, mlo;
	logic [7:0]  plen;
	logic [1:0]  status;
	result_t     r;

	always_comb begin
		plen = v6_s1 ? 8'd128 : 8'd32;
		status = err_s1 ? STATUS_ERROR : STATUS_OK;
		mhi = '1;
		mlo = '1;
		if (!err_s1 && slash_s1) begin
			if (badpfx_s1 || !pdig_s1 || pval_s1 > plen) begin
				status = STATUS_ERROR;
			end else begin
				plen = pval_s1;
				if (v6_s1) begin
					mhi = (pval_s1 >= 8'd64) ? '1 :
						~(64'hffff_ffff_ffff_ffff >> pval_s1[5:0]);
					// A full 128-bit prefix keeps every low bit.
					mlo = (pval_s1 <= 8'd64) ? '0 :
						(pval_s1 == 8'd128) ? '1 :
						~(64'hffff_ffff_ffff_ffff >> 6'(pval_s1 - 8'd64));
				end else begin
					mhi = '0;
					mlo = {32'd0, ~(32'hffff_ffff >> pval_s1[5:0])};
				end
				if (((hi_s1 & mhi) != hi_s1) || ((lo_s1 & mlo) != lo_s1))
					status = STATUS_TRIMMED;
			end
		end
		r.status = status;
		r.is_ipv6 = v6_s1;
		r.addr_high = hi_s1 & mhi;
		r.addr_low = lo_s1 & mlo;
		r.prefix_len = plen;
		if (status == STATUS_ERROR) r = '{status: STATUS_ERROR, default: '0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		res <= r;
	end

endmodule

// ===== hw/rtl/ctp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ctp_out_fifo: result queue
// Small register queue; its fill level sets the input full flag so that
// results still in flight always have room.
// ----------------------------------------------------------------------------
module ctp_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  ctp_pkg::result_t wdata,
	input  logic             rd,
	output logic             empty,
	output ctp_pkg::result_t rdata,
	output logic [2:0]       level
);
	import ctp_pkg::*;

	result_t    mem_q [8];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;

	assign empty = cnt_q == 4'd0;
	assign rdata = mem_q[rp_q];
	assign level = (cnt_q > 4'd7) ? 3'd7 : cnt_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 3'd1;
			if (rd && !empty) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + 4'(wr) - 4'(rd && !empty);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== hw/rtl/cidr_text_parser_unit.sv =====
// ----------------------------------------------------------------------------
// cidr_text_parser_unit: streaming IPv4/IPv6 CIDR text parser
// Accepts one character per cycle while not full; a result passes the scanner
// snapshot register and finishing stages 1 and 2 before it is queued.
// Throughput: one character per cycle while not full; full rises when
// the result queue holds five results, leaving room for up to three in flight.
// Reset: asynchronous, empties the queue and returns the scanner to the start
// of a string.
// ----------------------------------------------------------------------------
module cidr_text_parser_unit #(
	parameter int ENABLE_IPV6 = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic        is_ipv6,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic [7:0]  prefix_len
);
	import ctp_pkg::*;

	logic       acc, rec_valid, res_valid;
	scan_rec_t  rec;
	result_t    res, head;
	logic [2:0] level;

	assign acc = push && !full;
	assign full = level >= 3'd5;

	ctp_scanner u_scan (.clk, .arst_n, .in_valid(acc), .char_code, .is_last,
		.rec_valid, .rec);

	ctp_finish #(.ENABLE_IPV6(ENABLE_IPV6)) u_fin (.clk, .arst_n, .rec_valid, .rec,
		.res_valid, .res);

	ctp_out_fifo u_q (.clk, .arst_n, .wr(res_valid), .wdata(res), .rd(pop), .empty,
		.rdata(head), .level);

	assign status = head.status;
	assign is_ipv6 = head.is_ipv6;
	assign addr_high = head.addr_high;
	assign addr_low = head.addr_low;
	assign prefix_len = head.prefix_len;

endmodule
